/* src/tsd_pkg.sv */
`default_nettype none

package tsd_pkg;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_START = 2'd1,
      OP_STOP  = 2'd2,
      OP_FRAME = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      EV_NONE      = 3'd0,
      EV_ENTERED   = 3'd1,
      EV_HOLD_DONE = 3'd2,
      EV_RECOG     = 3'd3,
      EV_RESTART   = 3'd4
   } event_type;

   localparam logic REG_STEP_COUNT = 1'b0;
   localparam logic REG_WAIT_LAST  = 1'b1;

   localparam int CSR_AW = 3;

   // step index is 4 bits signed and the match mask 8 bits
   localparam int MAX_STEPS = 8;

   localparam logic [3:0] STEP_NONE = 4'hF;

   typedef struct packed {
      logic        strict;
      logic [20:0] tolerance;
      logic [20:0] window;
      logic [20:0] max_hold;
      logic [20:0] min_hold;
   } step_entry_type;

   // elapsed time (unsigned) against a signed 21-bit table value
   function automatic logic time_lt(input logic [31:0] t, input logic [20:0] v);
      return !v[20] && (t < {11'b0, v});
   endfunction

   function automatic logic time_gt(input logic [31:0] t, input logic [20:0] v);
      return v[20] || (t > {11'b0, v});
   endfunction

endpackage

`default_nettype wire

/* src/timed_sequence_detector_top.sv */
// Timed sequence detector.
// Input channel req_*: one transfer per item. tuser carries the opcode (write
// step entry, start, stop, frame); tdata carries the step entry fields, the
// frame timestamp and the per-step match mask. Output channel rsp_*: exactly
// one transfer per input item, in order: event code in tuser, current step and
// running flag in tdata.
// Step entries live in a one-port-write, one-port-read synchronous memory that
// is read when an item is accepted, with the step that the item ahead of it
// leaves as address, so a frame does not wait for its step entry.
// An accepted item is registered in the read stage and then in the output
// register, which drives rsp_tvalid. Throughput: one item per cycle while
// rsp_tready is high, set by the single read-modify step on the detector state.
// Reset clears the running state, sets step_count to 1 and drains both
// stages; the step memory keeps its contents and must be written before use.
// When rsp_tready is low, one item waits in the output register and one in
// the read stage; req_tready drops only once both are full.
// csr_* is an APB-style port: step_count at 0x0, wait_for_last_release at 0x4.
`default_nettype none

module timed_sequence_detector_top (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_tvalid,
   output logic                         req_tready,
   // [2:0] entry_index, [23:3] min_hold, [44:24] max_hold,
   // [65:45] transition_window, [86:66] interrupt_tolerance,
   // [87] strict_before_min, [119:88] timestamp, [127:120] match_mask
   input  wire  [127:0]                 req_tdata,
   // [1:0] opcode
   input  wire  [1:0]                   req_tuser,
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   // [3:0] step_index, [4] active, [7:5] zero
   output logic [7:0]                   rsp_tdata,
   // [2:0] event_res
   output logic [2:0]                   rsp_tuser,
   input  wire                          csr_psel,
   input  wire                          csr_penable,
   input  wire                          csr_pwrite,
   input  wire  [tsd_pkg::CSR_AW-1:0]   csr_paddr,
   input  wire  [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);
   import tsd_pkg::*;

   localparam int AW   = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
   localparam int CAPN = (MAX_STEPS > 15) ? 15 : MAX_STEPS;

   // config
   logic [3:0] step_count_ff, step_count_in;
   logic       wait_last_ff, wait_last_in;
   logic       csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      step_count_in = step_count_ff;
      wait_last_in  = wait_last_ff;
      if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_STEP_COUNT: step_count_in = csr_pwdata[3:0];
            REG_WAIT_LAST:  wait_last_in  = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_STEP_COUNT: csr_prdata = {28'b0, step_count_ff};
         REG_WAIT_LAST:  csr_prdata = {31'b0, wait_last_ff};
         default:        csr_prdata = 32'b0;
      endcase
   end

   // input fields
   opcode_type     req_op;
   step_entry_type req_entry;
   logic [2:0]     req_index;
   logic [31:0]    req_ts;
   logic [7:0]     req_mask;
   logic           req_accept;

   assign req_op              = opcode_type'(req_tuser);
   assign req_index           = req_tdata[2:0];
   assign req_entry.min_hold  = req_tdata[23:3];
   assign req_entry.max_hold  = req_tdata[44:24];
   assign req_entry.window    = req_tdata[65:45];
   assign req_entry.tolerance = req_tdata[86:66];
   assign req_entry.strict    = req_tdata[87];
   assign req_ts              = req_tdata[119:88];
   assign req_mask            = req_tdata[127:120];
   assign req_accept          = req_tvalid && req_tready;

   // read stage
   logic           s1_valid_ff, s1_valid_in;
   opcode_type     s1_op_ff;
   logic [31:0]    s1_ts_ff;
   logic [7:0]     s1_mask_ff;
   step_entry_type rd_entry_ff;

   step_entry_type step_mem [MAX_STEPS];
   logic [AW-1:0]  rd_addr;
   logic [AW-1:0]  wr_addr;
   logic           mem_we;

   // detector state
   logic        running_ff, running_in;
   logic [3:0]  cur_ff, cur_in;
   logic        hold_ff, hold_in;
   logic        intr_ff, intr_in;
   logic [31:0] start_ff, start_in;
   logic [31:0] intr_start_ff, intr_start_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   event_type   rsp_ev_ff;
   logic [3:0]  rsp_step_ff;
   logic        rsp_active_ff;

   logic        exec;
   logic        enter;
   event_type   ev;
   logic [3:0]  n_eff;
   logic [3:0]  nxt;
   logic        g_cur, g_nxt;
   logic        is_last;
   logic [31:0] tp, it;
   logic        win_check;

   assign exec       = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || exec;
   assign s1_valid_in = req_accept || (s1_valid_ff && !exec);
   assign rsp_valid_in = exec || (rsp_valid_ff && !rsp_tready);

   assign n_eff   = (step_count_ff > 4'(CAPN)) ? 4'(CAPN) : step_count_ff;
   assign nxt     = cur_ff + 4'd1;
   assign g_cur   = !cur_ff[3] && s1_mask_ff[cur_ff[2:0]];
   assign g_nxt   = !nxt[3] && s1_mask_ff[nxt[2:0]];
   assign is_last = (cur_ff == n_eff - 4'd1);
   assign tp      = s1_ts_ff - start_ff;
   assign it      = s1_ts_ff - intr_start_ff;
   assign win_check = !rd_entry_ff.window[20] && !is_last;

   assign enter = exec && (s1_op_ff == OP_FRAME) && running_ff && (n_eff != 4'd0)
                  && hold_ff && (nxt < n_eff) && g_nxt;

   assign rd_addr = enter ? AW'(nxt) : AW'(cur_ff);
   assign wr_addr = AW'(req_index);
   assign mem_we  = req_accept && (req_op == OP_WRITE) && (32'(req_index) < 32'(MAX_STEPS));

   always_comb begin
      running_in    = running_ff;
      cur_in        = cur_ff;
      hold_in       = hold_ff;
      intr_in       = intr_ff;
      start_in      = start_ff;
      intr_start_in = intr_start_ff;
      ev            = EV_NONE;
      if (exec) begin
         unique case (s1_op_ff)
            OP_WRITE: ;
            OP_START: begin
               if (!running_ff && (n_eff != 4'd0)) begin
                  running_in = 1'b1;
                  cur_in     = STEP_NONE;
                  hold_in    = 1'b1;
                  intr_in    = 1'b0;
               end
            end
            OP_STOP: begin
               running_in = 1'b0;
               cur_in     = STEP_NONE;
               hold_in    = 1'b0;
               intr_in    = 1'b0;
            end
            OP_FRAME: begin
               if (running_ff && (n_eff != 4'd0)) begin
                  if (hold_ff) begin
                     if (enter) begin
                        cur_in   = nxt;
                        hold_in  = 1'b0;
                        intr_in  = 1'b0;
                        start_in = s1_ts_ff;
                        ev       = EV_ENTERED;
                     end else if (!cur_ff[3]) begin
                        if (intr_ff) begin
                           if (time_lt(it, rd_entry_ff.tolerance) && g_cur) begin
                              intr_in = 1'b0;
                           end else if ((win_check && time_gt(it, rd_entry_ff.window)
                                         && time_gt(it, rd_entry_ff.tolerance))
                                        || (!win_check
                                            && time_gt(it, rd_entry_ff.tolerance))) begin
                              ev = (wait_last_ff && is_last) ? EV_RECOG : EV_RESTART;
                           end
                        end else if (g_cur) begin
                           if (!rd_entry_ff.max_hold[20] && (rd_entry_ff.max_hold != 21'd0)
                               && time_gt(tp, rd_entry_ff.max_hold)) begin
                              ev = (wait_last_ff && is_last) ? EV_RECOG : EV_RESTART;
                           end
                        end else begin
                           intr_in       = 1'b1;
                           intr_start_in = s1_ts_ff;
                        end
                     end
                  end else if (!cur_ff[3]) begin
                     if (time_lt(tp, rd_entry_ff.min_hold)) begin
                        if (!g_cur) begin
                           if (intr_ff || rd_entry_ff.strict) begin
                              if (rd_entry_ff.strict
                                  || time_gt(it, rd_entry_ff.tolerance)) begin
                                 ev = EV_RESTART;
                              end
                           end else begin
                              intr_in       = 1'b1;
                              intr_start_in = s1_ts_ff;
                           end
                        end else begin
                           intr_in = 1'b0;
                        end
                     end else if (!intr_ff || g_cur) begin
                        if (!wait_last_ff && is_last) begin
                           ev = EV_RECOG;
                        end else begin
                           hold_in = 1'b1;
                           ev      = EV_HOLD_DONE;
                        end
                     end
                  end
                  if (ev == EV_RECOG) begin
                     running_in = 1'b0;
                     cur_in     = STEP_NONE;
                     hold_in    = 1'b0;
                     intr_in    = 1'b0;
                  end else if (ev == EV_RESTART) begin
                     running_in = 1'b1;
                     cur_in     = STEP_NONE;
                     hold_in    = 1'b1;
                     intr_in    = 1'b0;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         step_mem[wr_addr] <= req_entry;
      end
      if (req_accept) begin
         rd_entry_ff <= step_mem[rd_addr];
         s1_op_ff    <= req_op;
         s1_ts_ff    <= req_ts;
         s1_mask_ff  <= req_mask;
      end
      if (exec) begin
         rsp_ev_ff     <= ev;
         rsp_step_ff   <= cur_in;
         rsp_active_ff <= running_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_count_ff <= 4'd1;
         wait_last_ff  <= 1'b0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         running_ff    <= 1'b0;
         cur_ff        <= STEP_NONE;
         hold_ff       <= 1'b0;
         intr_ff       <= 1'b0;
         start_ff      <= 32'b0;
         intr_start_ff <= 32'b0;
      end else begin
         step_count_ff <= step_count_in;
         wait_last_ff  <= wait_last_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         running_ff    <= running_in;
         cur_ff        <= cur_in;
         hold_ff       <= hold_in;
         intr_ff       <= intr_in;
         start_ff      <= start_in;
         intr_start_ff <= intr_start_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ev_ff;
   assign rsp_tdata  = {3'b0, rsp_active_ff, rsp_step_ff};

endmodule

`default_nettype wire

/* src/tsd_checker.sv */
`default_nettype none

module tsd_checker (
   input wire       clock,
   input wire       reset,
   input wire       rsp_tvalid,
   input wire       rsp_tready,
   input wire [7:0] rsp_tdata,
   input wire [2:0] rsp_tuser
);
   import tsd_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp transfer dropped or changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

   a_idle_no_step: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[4] |-> rsp_tdata[3:0] == STEP_NONE)
      else $error("stopped detector reports a step");

   a_recog_stops: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == EV_RECOG) |-> !rsp_tdata[4])
      else $error("detector still running after recognition");

   a_restart_state: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == EV_RESTART)
      |-> rsp_tdata[4] && (rsp_tdata[3:0] == STEP_NONE))
      else $error("restart left wrong state");

endmodule

bind timed_sequence_detector_top tsd_checker u_tsd_checker (.*);

`default_nettype wire

/* bench/testbench.sv */
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import tsd_pkg::*;

   localparam int STEPS       = MAX_STEPS;
   localparam int BIG         = 1048575;
   localparam int N_SEG       = 6;
   localparam int SEG_ITEMS   = 90;
   localparam int SETTLE      = 4;
   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_HOLD   = 400;
   localparam int SEG_STEPS [N_SEG] = '{8, 3, 15, 1, 5, 8};
   localparam int SEG_WAIT  [N_SEG] = '{0, 1, 1, 0, 1, 0};

   typedef struct {
      opcode_type  op;
      logic [2:0]  idx;
      logic [20:0] min_h, max_h, win, tol;
      logic        strict;
      logic [31:0] stamp;
      logic [7:0]  mask;
   } req_item_type;

   typedef struct {
      event_type  ev;
      logic [3:0] step;
      logic       act;
   } outcome_type;

   typedef struct {
      bit          csr;
      logic        reg_sel;
      int          reg_val;
      opcode_type  op;
      logic [2:0]  idx;
      int          min_h, max_h, win, tol;
      logic        strict;
      logic [31:0] stamp;
      logic [7:0]  mask;
      bit          fixed;
      event_type   ev;
      logic [3:0]  step;
      logic        act;
   } dir_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [7:0]   rsp_tdata;
   logic [2:0]   rsp_tuser;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   timed_sequence_detector_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   always #6 clock = ~clock;

   // detector state mirror
   logic        running = 1'b0;
   int          cur_step = -1;
   logic        hold_done = 1'b0;
   logic        intr_flag = 1'b0;
   logic [31:0] step_t0 = '0;
   logic [31:0] intr_t0 = '0;
   longint      min_tab [STEPS];
   longint      max_tab [STEPS];
   longint      win_tab [STEPS];
   longint      tol_tab [STEPS];
   logic        strict_tab [STEPS];
   logic [3:0]  cfg_steps = 4'd1;
   logic        cfg_wait = 1'b0;

   outcome_type result_q [$];
   int          mismatches = 0;
   int          cycles = 0;
   int          send_idle = 18;
   int          recv_idle = 75;
   int          hold_req = 0;

   // columns: csr, reg, value, op, idx, min, max, window, tolerance, strict,
   //          timestamp, mask, fixed, event, step, active
   dir_row_type dir_tab [29] = '{
      '{0, REG_STEP_COUNT, 0, OP_FRAME, 0, 0, 0, 0, 0, 0, 32'h0, 8'hFF, 1, EV_NONE, STEP_NONE, 0},
      '{0, REG_STEP_COUNT, 0, OP_WRITE, 0, 5, 20, -1, 3, 0, 0, 0, 1, EV_NONE, STEP_NONE, 0},
      '{0, REG_STEP_COUNT, 0, OP_WRITE, 1, 0, -1, 2, 1, 0, 0, 0, 1, EV_NONE, STEP_NONE, 0},
      '{0, REG_STEP_COUNT, 0, OP_WRITE, 2, 3, 10, -1, -1, 1, 0, 0, 1, EV_NONE, STEP_NONE, 0},
      '{0, REG_STEP_COUNT, 0, OP_WRITE, 3, 1, 1, 0, 0, 0, 0, 0, 1, EV_NONE, STEP_NONE, 0},
      '{0, REG_STEP_COUNT, 0, OP_WRITE, 4, 2, 8, 5, 2, 1, 0, 0, 1, EV_NONE, STEP_NONE, 0},
      '{0, REG_STEP_COUNT, 0, OP_WRITE, 5, 4, 12, 3, 4, 0, 0, 0, 1, EV_NONE, STEP_NONE, 0},
      '{0, REG_STEP_COUNT, 0, OP_WRITE, 6, 0, 0, BIG, 2, 0, 0, 0, 1, EV_NONE, STEP_NONE, 0},
      '{0, REG_STEP_COUNT, 0, OP_WRITE, 7, BIG, BIG, BIG, BIG, 1, 0, 0, 1,
        EV_NONE, STEP_NONE, 0},
      '{0, REG_STEP_COUNT, 0, OP_START, 0, 0, 0, 0, 0, 0, 0, 0, 1, EV_NONE, STEP_NONE, 1},
      '{0, REG_STEP_COUNT, 0, OP_FRAME, 0, 0, 0, 0, 0, 0, 32'd100, 8'h01, 0, EV_NONE, 0, 0},
      '{0, REG_STEP_COUNT, 0, OP_FRAME, 0, 0, 0, 0, 0, 0, 32'd102, 8'h00, 0, EV_NONE, 0, 0},
      '{0, REG_STEP_COUNT, 0, OP_FRAME, 0, 0, 0, 0, 0, 0, 32'd103, 8'h01, 0, EV_NONE, 0, 0},
      '{0, REG_STEP_COUNT, 0, OP_FRAME, 0, 0, 0, 0, 0, 0, 32'd105, 8'h01, 0, EV_NONE, 0, 0},
      '{0, REG_STEP_COUNT, 0, OP_STOP, 0, 0, 0, 0, 0, 0, 0, 0, 1, EV_NONE, STEP_NONE, 0},
      '{1, REG_STEP_COUNT, 0, OP_WRITE, 0, 0, 0, 0, 0, 0, 0, 0, 0, EV_NONE, 0, 0},
      '{0, REG_STEP_COUNT, 0, OP_START, 0, 0, 0, 0, 0, 0, 0, 0, 1, EV_NONE, STEP_NONE, 0},
      '{0, REG_STEP_COUNT, 0, OP_FRAME, 0, 0, 0, 0, 0, 0, 32'd200, 8'hFF, 1,
        EV_NONE, STEP_NONE, 0},
      '{1, REG_STEP_COUNT, 15, OP_WRITE, 0, 0, 0, 0, 0, 0, 0, 0, 0, EV_NONE, 0, 0},
      '{1, REG_WAIT_LAST, 1, OP_WRITE, 0, 0, 0, 0, 0, 0, 0, 0, 0, EV_NONE, 0, 0},
      '{0, REG_STEP_COUNT, 0, OP_START, 0, 0, 0, 0, 0, 0, 0, 0, 1, EV_NONE, STEP_NONE, 1},
      '{0, REG_STEP_COUNT, 0, OP_FRAME, 0, 0, 0, 0, 0, 0, 32'hFFFFFFFE, 8'hFF, 0,
        EV_NONE, 0, 0},
      '{0, REG_STEP_COUNT, 0, OP_FRAME, 0, 0, 0, 0, 0, 0, 32'd3, 8'hFF, 0, EV_NONE, 0, 0},
      '{0, REG_STEP_COUNT, 0, OP_FRAME, 0, 0, 0, 0, 0, 0, 32'd4, 8'h02, 0, EV_NONE, 0, 0},
      // step count lowered while step 1 is live
      '{1, REG_STEP_COUNT, 1, OP_WRITE, 0, 0, 0, 0, 0, 0, 0, 0, 0, EV_NONE, 0, 0},
      '{0, REG_STEP_COUNT, 0, OP_FRAME, 0, 0, 0, 0, 0, 0, 32'd4, 8'h00, 0, EV_NONE, 0, 0},
      '{0, REG_STEP_COUNT, 0, OP_FRAME, 0, 0, 0, 0, 0, 0, 32'd5, 8'h00, 0, EV_NONE, 0, 0},
      '{0, REG_STEP_COUNT, 0, OP_FRAME, 0, 0, 0, 0, 0, 0, 32'd1000000, 8'h00, 0,
        EV_NONE, 0, 0},
      '{0, REG_STEP_COUNT, 0, OP_STOP, 0, 0, 0, 0, 0, 0, 0, 0, 1, EV_NONE, STEP_NONE, 0}
   };

   function automatic longint span(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return longint'({32'b0, d});
   endfunction

   function automatic void halt_detector();
      running = 1'b0;
      cur_step = -1;
      hold_done = 1'b0;
      intr_flag = 1'b0;
   endfunction

   function automatic void rearm_detector();
      running = 1'b1;
      cur_step = -1;
      hold_done = 1'b1;
      intr_flag = 1'b0;
   endfunction

   function automatic void enqueue_result(input outcome_type o);
      result_q = {result_q, o};
   endfunction

   function automatic event_type recognize_or_rearm(input int n);
      if (cfg_wait && cur_step == n - 1) begin
         halt_detector();
         return EV_RECOG;
      end
      rearm_detector();
      return EV_RESTART;
   endfunction

   function automatic event_type frame_event(input logic [31:0] t_now, input logic [7:0] m,
                                             input int n);
      int     c;
      int     nx;
      bit     g;
      bit     chk;
      longint it;
      longint tp;
      c = cur_step;
      if (!running || n <= 0) return EV_NONE;
      it = span(t_now, intr_t0);
      tp = span(t_now, step_t0);
      if (hold_done) begin
         nx = c + 1;
         if (nx < n && m[nx]) begin
            cur_step = nx;
            hold_done = 1'b0;
            intr_flag = 1'b0;
            step_t0 = t_now;
            return EV_ENTERED;
         end
         if (c < 0 || c >= STEPS) return EV_NONE;
         if (intr_flag) begin
            chk = win_tab[c] >= 0 && c != n - 1;
            if (it < tol_tab[c] && m[c]) begin
               intr_flag = 1'b0;
            end else if ((chk && it > win_tab[c] && it > tol_tab[c]) ||
                         (!chk && it > tol_tab[c])) begin
               return recognize_or_rearm(n);
            end
         end else if (m[c]) begin
            if (max_tab[c] > 0 && tp > max_tab[c]) return recognize_or_rearm(n);
         end else begin
            intr_flag = 1'b1;
            intr_t0 = t_now;
         end
         return EV_NONE;
      end
      if (c < 0 || c >= STEPS) return EV_NONE;
      g = m[c];
      if (tp < min_tab[c]) begin
         if (!g) begin
            if (intr_flag || strict_tab[c]) begin
               if (strict_tab[c] || it > tol_tab[c]) begin
                  rearm_detector();
                  return EV_RESTART;
               end
            end else begin
               intr_flag = 1'b1;
               intr_t0 = t_now;
            end
         end else begin
            intr_flag = 1'b0;
         end
         return EV_NONE;
      end
      if (!intr_flag || g) begin
         if (!cfg_wait && c == n - 1) begin
            halt_detector();
            return EV_RECOG;
         end
         hold_done = 1'b1;
         return EV_HOLD_DONE;
      end
      return EV_NONE;
   endfunction

   function automatic outcome_type advance_detector(input req_item_type it);
      outcome_type r;
      int          n;
      n = (cfg_steps > 4'd8) ? STEPS : int'(cfg_steps);
      r.ev = EV_NONE;
      case (it.op)
         OP_WRITE: begin
            min_tab[it.idx] = longint'($signed(it.min_h));
            max_tab[it.idx] = longint'($signed(it.max_h));
            win_tab[it.idx] = longint'($signed(it.win));
            tol_tab[it.idx] = longint'($signed(it.tol));
            strict_tab[it.idx] = it.strict;
         end
         OP_START: if (!running && n > 0) rearm_detector();
         OP_STOP: halt_detector();
         default: r.ev = frame_event(it.stamp, it.mask, n);
      endcase
      r.step = 4'(cur_step);
      r.act = running;
      return r;
   endfunction

   function automatic logic [20:0] pick_time(input int lim);
      int r;
      r = $urandom_range(99);
      if (r < 8) return '1;
      if (r < 11) return 21'(BIG);
      if (r < 15) return 21'($urandom_range(BIG));
      return 21'($urandom_range(lim));
   endfunction

   task automatic report(input string note);
      mismatches++;
      if (mismatches <= 10) $display("mismatch %0d: %s", mismatches, note);
   endtask

   // called at a falling edge, leaves at a falling edge
   task automatic send_item(input req_item_type it, input bit fixed, input outcome_type fx);
      outcome_type got;
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= it.op;
      req_tdata <= {it.mask, it.stamp, it.strict, it.tol, it.win, it.max_h, it.min_h, it.idx};
      do @(posedge clock); while (!req_tready);
      got = advance_detector(it);
      if (fixed) enqueue_result(fx);
      else enqueue_result(got);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (result_q.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic csr_write(input logic sel, input logic [31:0] val);
      logic [31:0] rd;
      logic [31:0] keep;
      keep = (sel == REG_STEP_COUNT) ? 32'hF : 32'h1;
      csr_paddr <= {sel, 2'b00};
      csr_pwdata <= val;
      csr_pwrite <= 1'b1;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (sel == REG_STEP_COUNT) cfg_steps = val[3:0];
      else cfg_wait = val[0];
      @(negedge clock);
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rd = csr_prdata;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if ((rd & keep) !== (val & keep))
         report($sformatf("register %0d read 0x%0h, wrote 0x%0h", sel, rd, val));
   endtask

   // receiver side: random back-pressure plus requested long holds
   always @(negedge clock) begin
      int hold_left;
      if (hold_req > 0) begin
         hold_left = hold_req;
         hold_req = 0;
      end
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (result_q.size() == 0) begin
            report($sformatf("unexpected transfer ev %0d tdata 0x%0h", rsp_tuser, rsp_tdata));
         end else begin
            want = result_q.pop_front();
            if (rsp_tuser !== want.ev || rsp_tdata[3:0] !== want.step ||
                rsp_tdata[4] !== want.act || rsp_tdata[7:5] !== 3'b0)
               report({$sformatf("expected ev %0d step %0d active %0d, ",
                                 want.ev, $signed(want.step), want.act),
                       $sformatf("got ev %0d step %0d active %0d (tdata 0x%0h)",
                                 rsp_tuser, $signed(rsp_tdata[3:0]), rsp_tdata[4],
                                 rsp_tdata)});
         end
      end
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("timed_sequence_detector_top regression: fail");
      $finish;
   end

   initial begin
      req_item_type it;
      outcome_type  fx;
      int           r;
      logic [31:0]  now_ms;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (2) @(negedge clock);

      foreach (dir_tab[i]) begin
         if (dir_tab[i].csr) begin
            drain();
            csr_write(dir_tab[i].reg_sel, dir_tab[i].reg_val);
         end else begin
            it.op = dir_tab[i].op;
            it.idx = dir_tab[i].idx;
            it.min_h = 21'(dir_tab[i].min_h);
            it.max_h = 21'(dir_tab[i].max_h);
            it.win = 21'(dir_tab[i].win);
            it.tol = 21'(dir_tab[i].tol);
            it.strict = dir_tab[i].strict;
            it.stamp = dir_tab[i].stamp;
            it.mask = dir_tab[i].mask;
            fx.ev = dir_tab[i].ev;
            fx.step = dir_tab[i].step;
            fx.act = dir_tab[i].act;
            send_item(it, dir_tab[i].fixed, fx);
         end
      end

      for (int s = 0; s < N_SEG; s++) begin
         drain();
         csr_write(REG_STEP_COUNT, SEG_STEPS[s]);
         csr_write(REG_WAIT_LAST, SEG_WAIT[s]);
         send_idle = (s < 2) ? 18 : (s < 4) ? 75 : 0;
         recv_idle = (s < 2) ? 75 : (s < 4) ? 18 : 0;
         now_ms = (s == 1) ? 32'hFFFFFF00 + $urandom_range(200) : $urandom;
         for (int k = 0; k < SEG_ITEMS; k++) begin
            if (s == 0 && k == 30) hold_req = LONG_HOLD;
            if (s == 2 && k == 45) drain();
            it.idx = 3'($urandom);
            it.min_h = 21'($urandom);
            it.max_h = 21'($urandom);
            it.win = 21'($urandom);
            it.tol = 21'($urandom);
            it.strict = 1'($urandom);
            it.stamp = $urandom;
            it.mask = 8'($urandom);
            r = $urandom_range(99);
            if (r < 4) begin
               it.op = OP_WRITE;
               it.min_h = pick_time(12);
               it.max_h = pick_time(30);
               it.win = pick_time(20);
               it.tol = pick_time(10);
               it.strict = ($urandom_range(4) == 0);
            end else if (r < 7) begin
               it.op = OP_STOP;
            end else if (r < 10 || (!running && r < 70)) begin
               it.op = OP_START;
            end else begin
               it.op = OP_FRAME;
               r = $urandom_range(99);
               if (r < 70) now_ms += $urandom_range(4);
               else if (r < 90) now_ms += $urandom_range(25, 5);
               else if (r < 98) now_ms += $urandom_range(200, 26);
               else now_ms += $urandom;
               it.stamp = now_ms;
               it.mask = 8'($urandom_range(255) & $urandom_range(255));
               if (cur_step < STEPS - 1 && $urandom_range(99) < 55) it.mask[cur_step + 1] = 1'b1;
               if (cur_step >= 0) it.mask[cur_step] = ($urandom_range(99) < 75);
            end
            send_item(it, 1'b0, fx);
         end
      end

      drain();
      if (mismatches == 0 && result_q.size() == 0) begin
         $display("timed_sequence_detector_top regression: pass");
      end else begin
         $display("timed_sequence_detector_top regression: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
